// ===== sv/rrq_pkg.sv =====
package rrq_pkg;

    // Thread id width, fixed by the request and result fields
    localparam int ID_W = 5;

    // Default table size
    localparam int MAX_THREADS_DEF = 32;

    // Operation codes of a request
    localparam logic [1:0] KIND_YIELD = 2'd0;
    localparam logic [1:0] KIND_BLOCK = 2'd1;
    localparam logic [1:0] KIND_WAKE  = 2'd2;
    localparam logic [1:0] KIND_FORCE = 2'd3;

    // Per-cycle command to the queue cells
    typedef struct packed {
        logic            shift;  // every cell takes its neighbour's id (pop head)
        logic            wr;     // selected cell loads din
        logic [ID_W-1:0] din;
    } rrq_ctl_t;

endpackage

// ===== sv/round_robin_run_queue_unit.sv =====
// Yield, block, wake and a rejected force: taken in IDLE, run in EXEC once the result slot
// is free, result registered. Accepted force: EXEC, then SCAN pops each queued id once and
// requeues it at the tail unless it is the target. Requests are taken only in IDLE.
// Reset (rst_n, async, active low): queue empty, idle and current thread 0, only thread 0 runnable.
// The queue cells hold payload only; no clearing pass is needed.
module round_robin_run_queue_unit #(
    parameter int MAX_THREADS = rrq_pkg::MAX_THREADS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // request channel
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [1:0]               kind,
    input  logic [rrq_pkg::ID_W-1:0] thread_id,
    // result channel
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [rrq_pkg::ID_W-1:0] run_tid,
    output logic                     switched,
    output logic                     status,
    // idle thread register write
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [rrq_pkg::ID_W-1:0] idle_tid
);
    import rrq_pkg::*;

    localparam int IDX_W = $clog2(MAX_THREADS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);
    localparam int EXT_W = ID_W + IDX_W;

    // Sequencer: IDLE takes a request, EXEC runs it, SCAN rotates the
    // queue for a force and then finishes it once the count reaches zero.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]             state_reg,   state_next;
    logic [1:0]             kind_reg,    kind_next;
    logic [ID_W-1:0]        tid_reg,     tid_next;
    logic [ID_W-1:0]        cur_reg,     cur_next;
    logic [ID_W-1:0]        idle_reg,    idle_next;
    logic [CNT_W-1:0]       count_reg,   count_next;
    logic [CNT_W-1:0]       scan_reg,    scan_next;
    logic [MAX_THREADS-1:0] flags_reg,   flags_next;
    logic                   res_valid_reg, res_valid_next;
    logic [ID_W-1:0]        run_tid_reg,     run_tid_next;
    logic                   switched_reg,    switched_next;
    logic                   status_reg,      status_next;

    rrq_ctl_t         ctl;
    logic [IDX_W-1:0] wpos;
    logic [ID_W-1:0]  head;

    logic             slot_free;
    logic             emit, emit_sw, emit_st;
    logic             empty, not_full, push, keep;
    logic [CNT_W-1:0] cnt_dec;
    logic [EXT_W-1:0] cur_wide, tid_wide;
    logic [IDX_W-1:0] cur_idx, tid_idx;
    logic             cur_in, tid_in, tid_runnable;

    rrq_chain #(
        .MAX_THREADS (MAX_THREADS)
    ) u_chain (
        .clk  (clk),
        .ctl  (ctl),
        .wpos (wpos),
        .head (head)
    );

    // Thread ids are 5 bits; the flag table may be narrower or wider.
    assign cur_wide     = {{IDX_W{1'b0}}, cur_reg};
    assign tid_wide     = {{IDX_W{1'b0}}, tid_reg};
    assign cur_idx      = cur_wide[IDX_W-1:0];
    assign tid_idx      = tid_wide[IDX_W-1:0];
    assign cur_in       = cur_wide < EXT_W'(MAX_THREADS);
    assign tid_in       = tid_wide < EXT_W'(MAX_THREADS);
    assign tid_runnable = tid_in && flags_reg[tid_idx];

    assign empty     = (count_reg == '0);
    assign not_full  = count_reg < CNT_W'(MAX_THREADS);
    assign cnt_dec   = count_reg - CNT_W'(1);
    assign slot_free = !res_valid_reg || !res_stall;
    assign keep      = (head != tid_reg);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        tid_next   = tid_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        flags_next = flags_reg;
        ctl        = '0;
        wpos       = '0;
        emit       = 1'b0;
        emit_sw    = 1'b0;
        emit_st    = 1'b0;
        push       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = kind;
                    tid_next   = thread_id;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (kind_reg)
                    KIND_YIELD:
                    begin
                        if (slot_free)
                        begin
                            if (cur_in)
                            begin
                                flags_next[cur_idx] = 1'b1;
                            end
                            push = (cur_reg != idle_reg) && not_full;
                            // empty queue: the pushed thread pops straight back
                            if (empty)
                            begin
                                cur_next = push ? cur_reg : idle_reg;
                            end
                            else
                            begin
                                ctl.shift  = 1'b1;
                                ctl.wr     = push;
                                ctl.din    = cur_reg;
                                wpos       = cnt_dec[IDX_W-1:0];
                                cur_next   = head;
                                count_next = cnt_dec + CNT_W'(push);
                            end
                            emit       = 1'b1;
                            emit_sw    = 1'b1;
                            state_next = S_IDLE;
                        end
                    end

                    KIND_BLOCK:
                    begin
                        if (slot_free)
                        begin
                            if (cur_in)
                            begin
                                flags_next[cur_idx] = 1'b0;
                            end
                            if (empty)
                            begin
                                cur_next = idle_reg;
                            end
                            else
                            begin
                                ctl.shift  = 1'b1;
                                cur_next   = head;
                                count_next = cnt_dec;
                            end
                            emit       = 1'b1;
                            emit_sw    = 1'b1;
                            state_next = S_IDLE;
                        end
                    end

                    KIND_WAKE:
                    begin
                        if (slot_free)
                        begin
                            if (tid_runnable || !tid_in)
                            begin
                                emit_st = 1'b1;
                            end
                            else
                            begin
                                flags_next[tid_idx] = 1'b1;
                                if (not_full)
                                begin
                                    ctl.wr     = 1'b1;
                                    ctl.din    = tid_reg;
                                    wpos       = count_reg[IDX_W-1:0];
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end

                    KIND_FORCE:
                    begin
                        if (!tid_runnable)
                        begin
                            if (slot_free)
                            begin
                                emit       = 1'b1;
                                emit_st    = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            if (cur_in)
                            begin
                                flags_next[cur_idx] = 1'b1;
                            end
                            scan_next  = count_reg;
                            state_next = S_SCAN;
                        end
                    end
                endcase
            end

            S_SCAN:
            begin
                if (scan_reg != '0)
                begin
                    // pop the head and requeue it at the tail unless it is the target
                    ctl.shift  = 1'b1;
                    ctl.wr     = keep;
                    ctl.din    = head;
                    wpos       = cnt_dec[IDX_W-1:0];
                    count_next = cnt_dec + CNT_W'(keep);
                    scan_next  = scan_reg - CNT_W'(1);
                end
                else if (slot_free)
                begin
                    if ((cur_reg != tid_reg) && not_full)
                    begin
                        ctl.wr     = 1'b1;
                        ctl.din    = cur_reg;
                        wpos       = count_reg[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                    cur_next   = tid_reg;
                    emit       = 1'b1;
                    emit_sw    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        idle_next      = cfg_valid ? idle_tid : idle_reg;
        res_valid_next = emit || (res_valid_reg && res_stall);
        run_tid_next   = emit ? cur_next : run_tid_reg;
        switched_next  = emit ? emit_sw  : switched_reg;
        status_next    = emit ? emit_st  : status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            idle_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            flags_reg     <= MAX_THREADS'(1);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            idle_reg      <= idle_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            flags_reg     <= flags_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        tid_reg      <= tid_next;
        run_tid_reg  <= run_tid_next;
        switched_reg <= switched_next;
        status_reg   <= status_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign run_tid   = run_tid_reg;
    assign switched  = switched_reg;
    assign status    = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_THREADS))
        else $error("queue count above table size");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> scan_reg <= count_reg)
        else $error("rotation counter exceeds queue length");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == S_EXEC)
        else $error("accepted request not executed");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) != S_IDLE)
        else $error("result raised without a request in flight");

endmodule

// ===== sv/rrq_cell.sv =====
module rrq_cell (
    input  logic                  clk,
    input  rrq_pkg::rrq_ctl_t     ctl,
    input  logic                  sel,
    input  logic [rrq_pkg::ID_W-1:0] nbr_id,
    output logic [rrq_pkg::ID_W-1:0] id
);
    import rrq_pkg::*;

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;

    // write wins over shift: it lands after the pop
    always_comb
    begin
        if (ctl.wr && sel)
        begin
            id_next = ctl.din;
        end
        else if (ctl.shift)
        begin
            id_next = nbr_id;
        end
        else
        begin
            id_next = id_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;

endmodule

// ===== sv/rrq_chain.sv =====
module rrq_chain #(
    parameter int MAX_THREADS = rrq_pkg::MAX_THREADS_DEF
) (
    input  logic                              clk,
    input  rrq_pkg::rrq_ctl_t                 ctl,
    input  logic [$clog2(MAX_THREADS)-1:0]    wpos,
    output logic [rrq_pkg::ID_W-1:0]          head
);
    import rrq_pkg::*;

    localparam int IDX_W = $clog2(MAX_THREADS);

    logic [ID_W-1:0] cell_id [MAX_THREADS];

    genvar i;
    generate
        for (i = 0; i < MAX_THREADS; i++)
        begin : g_cell
            logic [ID_W-1:0] nbr;
            logic            sel;

            // tail cell has no neighbour behind it
            if (i == MAX_THREADS - 1)
            begin : g_tail
                assign nbr = cell_id[i];
            end
            else
            begin : g_body
                assign nbr = cell_id[i+1];
            end

            assign sel = (wpos == IDX_W'(i));

            rrq_cell u_cell (
                .clk    (clk),
                .ctl    (ctl),
                .sel    (sel),
                .nbr_id (nbr),
                .id     (cell_id[i])
            );
        end
    endgenerate

    assign head = cell_id[0];

endmodule

// ===== bench/run_queue_checker.sv =====
`timescale 1ns / 100ps

// Watches the request, result and idle-thread write channels, keeps its own copy of the
// scheduler state and compares every result against the oldest pending prediction.
module run_queue_checker
    import rrq_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  logic [1:0]      kind,
    input  logic [ID_W-1:0] thread_id,
    input  logic            res_valid,
    input  logic            res_stall,
    input  logic [ID_W-1:0] run_tid,
    input  logic            switched,
    input  logic            status,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [ID_W-1:0] idle_tid,
    output int              outstanding,
    output int              mismatches,
    output int              results_seen
);

    localparam int NT = MAX_THREADS_DEF;

    typedef struct packed {
        logic [ID_W-1:0] next_id;
        logic            swap;
        logic            rejected;
    } sched_result_t;

    logic [ID_W-1:0] ring [NT];
    int unsigned     ring_head;
    int unsigned     ring_len;
    logic [NT-1:0]   runnable;
    logic [ID_W-1:0] running;
    logic [ID_W-1:0] idle_id;
    sched_result_t   awaited [$];
    sched_result_t   due;

    // full queue: the id is dropped
    function automatic void enqueue_thread(input logic [ID_W-1:0] id);
        if (ring_len >= NT)
            return;
        ring[(ring_head + ring_len) % NT] = id;
        ring_len++;
    endfunction

    function automatic logic [ID_W-1:0] dequeue_or_idle();
        logic [ID_W-1:0] id;
        if (ring_len == 0)
            return idle_id;
        id = ring[ring_head];
        ring_head = (ring_head + 1) % NT;
        ring_len--;
        return id;
    endfunction

    // drop every entry of id, order of the rest kept
    function automatic void purge_thread(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] kept [NT];
        int unsigned     n;
        n = 0;
        for (int unsigned i = 0; i < ring_len; i++)
        begin
            if (ring[(ring_head + i) % NT] != id)
            begin
                kept[n] = ring[(ring_head + i) % NT];
                n++;
            end
        end
        for (int unsigned i = 0; i < n; i++)
            ring[i] = kept[i];
        ring_head = 0;
        ring_len  = n;
    endfunction

    function automatic sched_result_t schedule(input logic [1:0] op,
                                               input logic [ID_W-1:0] tid);
        sched_result_t r;
        r.swap     = 1'b0;
        r.rejected = 1'b0;
        case (op)
            KIND_YIELD:
            begin
                runnable[running] = 1'b1;
                if (running != idle_id)
                    enqueue_thread(running);
                running = dequeue_or_idle();
                r.swap  = 1'b1;
            end
            KIND_BLOCK:
            begin
                runnable[running] = 1'b0;
                running = dequeue_or_idle();
                r.swap  = 1'b1;
            end
            KIND_WAKE:
            begin
                if (runnable[tid])
                    r.rejected = 1'b1;
                else
                begin
                    runnable[tid] = 1'b1;
                    enqueue_thread(tid);
                end
            end
            default:
            begin
                if (!runnable[tid])
                    r.rejected = 1'b1;
                else
                begin
                    runnable[running] = 1'b1;
                    purge_thread(tid);
                    if (running != tid)
                        enqueue_thread(running);
                    running = tid;
                    r.swap  = 1'b1;
                end
            end
        endcase
        r.next_id = running;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_head   = 0;
            ring_len    = 0;
            runnable    = '0;
            runnable[0] = 1'b1;
            running     = '0;
            idle_id     = '0;
            awaited.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                idle_id = idle_tid;
            if (res_valid && !res_stall)
            begin
                if (awaited.size() == 0)
                begin
                    $error("result with no request pending: run_tid %0d", run_tid);
                    mismatches++;
                end
                else
                begin
                    due = awaited.pop_front();
                    results_seen++;
                    if (run_tid !== due.next_id)
                    begin
                        $error("run_tid: expected %0d, got %0d", due.next_id, run_tid);
                        mismatches++;
                    end
                    if (switched !== due.swap)
                    begin
                        $error("switched: expected %0d, got %0d", due.swap, switched);
                        mismatches++;
                    end
                    if (status !== due.rejected)
                    begin
                        $error("status: expected %0d, got %0d", due.rejected, status);
                        mismatches++;
                    end
                end
            end
            if (req_valid && !req_stall)
                awaited.push_back(schedule(kind, thread_id));
            outstanding <= awaited.size();
        end
    end

endmodule

// ===== bench/round_robin_run_queue_unit_tb.sv =====
`timescale 1ns / 100ps

// Top of the run queue bench: drives requests and idle-thread writes, lets the
// result side stall on its own pattern, and gives the verdict from the checker's count.
module round_robin_run_queue_unit_tb;

    import rrq_pkg::*;

    localparam int TARGET_REQS = 1850;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            req_valid = 1'b0;
    logic [1:0]      kind      = KIND_YIELD;
    logic [ID_W-1:0] thread_id = '0;
    logic            res_stall = 1'b0;
    logic            cfg_valid = 1'b0;
    logic [ID_W-1:0] idle_tid  = '0;

    logic            req_stall;
    logic            res_valid;
    logic [ID_W-1:0] run_tid;
    logic            switched;
    logic            status;
    logic            cfg_ready;

    int outstanding;
    int mismatches;
    int results_seen;

    // bookkeeping for the summary
    int sent;
    int op_count [4];
    int idle_writes;
    int burst_left;

    // stall pattern state
    int stall_mode;
    int stall_mode_left;
    int stall_hold;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    round_robin_run_queue_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (kind),
        .thread_id (thread_id),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .run_tid   (run_tid),
        .switched  (switched),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .idle_tid  (idle_tid)
    );

    run_queue_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .thread_id    (thread_id),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .run_tid      (run_tid),
        .switched     (switched),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .idle_tid     (idle_tid),
        .outstanding  (outstanding),
        .mismatches   (mismatches),
        .results_seen (results_seen)
    );

    // Result side back-pressure. Three modes, each held for a random stretch:
    // never stall, stall on roughly one cycle in four, or alternate runs of
    // stalling and flowing of random length.
    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      <= $urandom_range(0, 2);
            stall_mode_left <= $urandom_range(64, 256);
        end
        else
            stall_mode_left <= stall_mode_left - 1;

        case (stall_mode)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_hold == 0)
                begin
                    res_stall  <= ~res_stall;
                    stall_hold <= $urandom_range(1, 20);
                end
                else
                    stall_hold <= stall_hold - 1;
            end
        endcase
    end

    // One request. Requests go out in bursts; between bursts the sender drops
    // valid for a random gap, though now and then a burst starts with no gap,
    // and now and then a burst runs long. Valid stays high from one request to
    // the next inside a burst, and the payload holds while the block stalls.
    task automatic issue(input logic [1:0] op, input logic [ID_W-1:0] tid);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        kind      <= op;
        thread_id <= tid;
        do
            @(posedge clk);
        while (req_stall);
        op_count[op]++;
        sent++;
    endtask

    // Hold off the sender until every pending result has come back, then a few
    // spare cycles so the block is truly idle.
    task automatic settle();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    // Only called with the block idle (after settle).
    task automatic write_idle(input logic [ID_W-1:0] id);
        cfg_valid <= 1'b1;
        idle_tid  <= id;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        idle_writes++;
    endtask

    // General mix of operations. A narrow id set keeps wake and force hitting
    // threads whose state matters; the wide set is closer to noise.
    task automatic run_mix(input bit narrow, input int n);
        logic [1:0]      op;
        logic [ID_W-1:0] tid;
        int              r;
        repeat (n)
        begin
            r   = $urandom_range(0, 9);
            op  = (r < 3) ? KIND_YIELD : (r < 5) ? KIND_BLOCK : (r < 8) ? KIND_WAKE : KIND_FORCE;
            tid = narrow ? ID_W'($urandom_range(0, 5)) : ID_W'($urandom_range(0, 31));
            issue(op, tid);
        end
    endtask

    // Block until the queue is likely drained (the idle thread then blocks
    // itself), wake every id in a shuffled order, which can fill the queue
    // to the brim, then churn (forces, yields, blocks) so pushes meet a full queue.
    task automatic fill_and_churn(input int n);
        int order [32];
        int j;
        int tmp;
        int r;
        for (int i = 0; i < 32; i++)
            order[i] = i;
        for (int i = 31; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        repeat ($urandom_range(4, 34))
            issue(KIND_BLOCK, ID_W'($urandom_range(0, 31)));
        for (int i = 0; i < 32; i++)
            issue(KIND_WAKE, ID_W'(order[i]));
        repeat (n)
        begin
            r = $urandom_range(0, 9);
            issue((r < 5) ? KIND_FORCE : (r < 8) ? KIND_YIELD : KIND_BLOCK,
                  ID_W'($urandom_range(0, 31)));
        end
    endtask

    initial
    begin
        int phase;
        int style;
        logic [ID_W-1:0] idle_pick;

        phase = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk from reset: idle thread 0 is current and the only runnable one.
        issue(KIND_YIELD, 5'd31);  // idle yields, empty queue; id field ignored
        issue(KIND_WAKE,  5'd0);   // idle already runnable: rejected
        issue(KIND_FORCE, 5'd7);   // target not runnable: rejected
        issue(KIND_WAKE,  5'd31);
        issue(KIND_WAKE,  5'd1);
        issue(KIND_WAKE,  5'd31);  // already runnable: rejected
        issue(KIND_FORCE, 5'd31);  // force away from idle: idle gets queued
        issue(KIND_FORCE, 5'd31);  // force to the current thread
        issue(KIND_YIELD, 5'd0);
        issue(KIND_BLOCK, 5'd0);
        issue(KIND_FORCE, 5'd1);   // 1 was just blocked: rejected
        issue(KIND_WAKE,  5'd1);
        issue(KIND_FORCE, 5'd1);
        issue(KIND_BLOCK, 5'd31);
        issue(KIND_BLOCK, 5'd0);
        issue(KIND_BLOCK, 5'd0);   // idle blocks itself on an empty queue
        issue(KIND_FORCE, 5'd0);   // idle not runnable now: rejected
        issue(KIND_WAKE,  5'd0);   // wake of the idle thread, queued like any other
        issue(KIND_FORCE, 5'd0);   // force to current idle, its queue entry purged
        issue(KIND_YIELD, 5'd0);

        // Random phases. Each starts from an idle block with a fresh idle-thread
        // id: the extremes first, then ids from the narrow set or anywhere.
        while (sent < TARGET_REQS)
        begin
            settle();
            case (phase)
                0:       idle_pick = 5'd0;
                1:       idle_pick = 5'd31;
                default: idle_pick = $urandom_range(0, 1) ? ID_W'($urandom_range(0, 5))
                                                          : ID_W'($urandom_range(0, 31));
            endcase
            write_idle(idle_pick);
            style = (phase < 3) ? phase : $urandom_range(0, 3);
            case (style)
                0:       fill_and_churn($urandom_range(40, 100));
                1:       run_mix(1'b1, $urandom_range(100, 200));
                2:       run_mix(1'b0, $urandom_range(80, 160));
                default: fill_and_churn($urandom_range(20, 60));
            endcase
            phase++;
        end

        settle();
        $display("covered %0d requests (%0d yield, %0d block, %0d wake, %0d force),",
                 sent, op_count[KIND_YIELD], op_count[KIND_BLOCK], op_count[KIND_WAKE],
                 op_count[KIND_FORCE]);
        $display("%0d results checked, idle thread rewritten %0d times over %0d phases",
                 results_seen, idle_writes, phase);
        if (mismatches == 0)
            $display("PASS round_robin_run_queue_unit");
        else
            $display("FAIL round_robin_run_queue_unit");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #6_000_000;
        $display("FAIL round_robin_run_queue_unit");
        $finish;
    end

endmodule
